FILE: rtl/tvs_pkg.sv
package tvs_pkg;

  // Fixed point position of the time factor and width of the seconds fields.
  localparam int unsigned FACTOR_FRAC_BITS = 32;
  localparam int unsigned SECONDS_BITS     = 41;

  // Field widths.
  localparam int unsigned FACTOR_W = 48;
  localparam int unsigned OFFSET_W = 63;
  localparam int unsigned SUB_W    = 30;
  localparam int unsigned SCAL_W   = 32;

  // Datapath widths of the shared multiply and divide unit.
  localparam int unsigned WIDE_W   = 128;
  localparam int unsigned NARROW_W = 64;
  localparam int unsigned CNT_W    = $clog2(WIDE_W);

  // Subunits per second and nanoseconds per microsecond.
  localparam logic [SUB_W-1:0] NS_PER_S  = 30'd1000000000;
  localparam logic [SUB_W-1:0] US_PER_S  = 30'd1000000;
  localparam logic [SUB_W-1:0] NS_PER_US = 30'd1000;

  // Jitter generator.
  localparam logic [SCAL_W-1:0] JIT_MULT = 32'd16807;
  localparam int unsigned       JIT_BITS = 23;

  // Reset value of the factor: 1.0.
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 48'd1 << FACTOR_FRAC_BITS;

  typedef enum logic [1:0] {
    OP_MUL_TS = 2'd0,
    OP_DIV_TS = 2'd1,
    OP_MUL_SC = 2'd2,
    OP_DIV_SC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OFS_NONE     = 2'd0,
    OFS_ADD_POST = 2'd1,
    OFS_SUB_PRE  = 2'd2
  } ofs_mode_e;

  typedef enum logic {
    CFG_TIME_FACTOR = 1'b0,
    CFG_OFFSET_NS   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  // Request to the shared multiply and divide unit.
  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

  // Status of the shared multiply and divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_OFS_DIV, ST_OFS_DIVW, ST_OFS_US, ST_OFS_USW, ST_PRE_ADD,
    ST_FD, ST_FDW, ST_FD_FIN, ST_SCALE, ST_MI, ST_MIW, ST_MX, ST_MXW,
    ST_DI, ST_DIW, ST_XR, ST_XRW, ST_XABS, ST_RD, ST_RDW, ST_IU, ST_IUW,
    ST_POST_ADD, ST_OU, ST_OUW, ST_SM, ST_SMW, ST_SD, ST_SDW, ST_JIT,
    ST_JM, ST_JMW, ST_SAT
  } tvs_state_e;

endpackage

FILE: rtl/time_value_scaler.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid_i/tready_o       one request: operation and operands
// m_axis    out        m_axis_tvalid_o/tready_i       one result per request
// cfg       in         cfg_valid_i/cfg_ready_o        register index and write data
//
// One request at a time goes through a sequencer around one bit-serial unit.
// A division holds the sequencer through its start, all 128 quotient bits and
// done; a multiply until no set bit is left in its multiplier.
// A finished request also waits for the output register to free.
// A new request is taken while the previous result waits in the output
// register. Reset sets the factor to 1.0, the offset to 0 and the seed to 1.
module time_value_scaler
  import tvs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // round_up, offset_mode, in_seconds, in_subunit, scalar_in, zero pad
  input  logic [111:0] s_axis_tdata_i,
  // operation, use_micro
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_seconds, out_subunit, scalar_out, zero pad
  output logic [103:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [62:0]  cfg_data_i
);

  localparam int unsigned SEC_W = SECONDS_BITS;

  tvs_state_e state_q, state_d;

  // Configuration and generator state.
  logic [FACTOR_W-1:0] tf_q;
  logic [OFFSET_W-1:0] off_q;
  logic [SCAL_W-1:0]   seed_q, seed_d;

  // Request fields.
  op_e              op_q;
  logic             micro_q;
  logic             up_q;
  ofs_mode_e        mode_q;
  logic [SCAL_W-1:0] scal_q;
  logic             post_q;

  // Working values.
  logic [NARROW_W-1:0] s_q;
  logic [SUB_W-1:0]    sub_q;
  logic [NARROW_W-1:0] v_q;
  logic [NARROW_W-1:0] osec_q;
  logic [31:0]         osub_q;
  logic [SUB_W-1:0]    fr_q;
  logic [NARROW_W-1:0] m_q;
  logic                neg_q;
  logic                xneg_q;
  logic [WIDE_W-1:0]   iabs_q;
  logic [FACTOR_W-1:0] rabs_q;
  logic [FACTOR_W-1:0] den_q;
  logic [WIDE_W-1:0]   xpos_q;
  logic [WIDE_W-1:0]   x_q;
  logic [WIDE_W-1:0]   rnd_q;
  logic [WIDE_W-1:0]   t_q;
  logic [WIDE_W-1:0]   q_q;
  logic [SUB_W-1:0]    rr_q;

  // Output register.
  logic              ov_q;
  logic [SEC_W-1:0]  o_sec_q;
  logic [SUB_W-1:0]  o_sub_q;
  logic [SCAL_W-1:0] o_scal_q;
  logic              out_load;
  logic              out_free;

  // Shared arithmetic unit.
  md_req_t             md_req;
  md_rsp_t             md_rsp;
  logic [WIDE_W-1:0]   md_a;
  logic [NARROW_W-1:0] md_b;
  logic [WIDE_W-1:0]   md_res;
  logic [NARROW_W-1:0] md_rem;

  tvs_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .rsp_o  (md_rsp),
    .res_o  (md_res),
    .rem_o  (md_rem)
  );

  // Derived operands.
  logic                s_hs;
  logic [FACTOR_W-1:0] fsel;
  logic [SUB_W-1:0]    unit;
  logic [NARROW_W-1:0] off_ext;
  logic [NARROW_W-1:0] v_abs;
  logic [9:0]          ofs_k;
  logic [WIDE_W-1:0]   t_abs;
  logic [WIDE_W-1:0]   iabs_sgn;
  logic [FACTOR_W-1:0] den_m1;
  logic [WIDE_W-1:0]   n_rd;
  logic [NARROW_W-1:0] d_rd;
  logic                rem_nz;
  logic [32:0]         pre_sum;
  logic                pos_ovf;
  logic                neg_ovf;
  ofs_mode_e           mode_in;

  assign s_hs     = s_axis_tvalid_i & s_axis_tready_o;
  assign fsel     = (tf_q == '0) ? FACTOR_W'(1) : tf_q;
  assign unit     = micro_q ? US_PER_S : NS_PER_S;
  assign off_ext  = {off_q[OFFSET_W-1], off_q};
  assign v_abs    = v_q[NARROW_W-1] ? (~v_q + 64'd1) : v_q;
  assign ofs_k    = up_q ? (v_q[NARROW_W-1] ? 10'd0 : 10'd999) : 10'd500;
  assign t_abs    = t_q[WIDE_W-1] ? (~t_q + 128'd1) : t_q;
  assign iabs_sgn = neg_q ? (~iabs_q + 128'd1) : iabs_q;
  assign den_m1   = den_q - 48'd1;
  assign rem_nz   = md_rem != '0;
  assign pre_sum  = {3'b000, sub_q} + {osub_q[31], osub_q};
  assign pos_ovf  = !q_q[WIDE_W-1] && (|q_q[WIDE_W-2:SEC_W-1]);
  assign neg_ovf  = q_q[WIDE_W-1] && !(&q_q[WIDE_W-2:SEC_W-1]);
  assign out_free = !ov_q || m_axis_tready_i;

  // Rounding division operands: nearest, ceiling of a positive value, or
  // truncation of the magnitude of a negative value.
  always_comb begin
    if (!up_q) begin
      n_rd = (x_q << 1) + WIDE_W'(den_q);
      d_rd = NARROW_W'({den_q, 1'b0});
    end else begin
      n_rd = xneg_q ? x_q : (x_q + WIDE_W'(den_m1));
      d_rd = NARROW_W'(den_q);
    end
  end

  // Offset mode decode; the unused code means no offset.
  always_comb begin
    unique case (s_axis_tdata_i[2:1])
      OFS_ADD_POST: mode_in = OFS_ADD_POST;
      OFS_SUB_PRE:  mode_in = OFS_SUB_PRE;
      default:      mode_in = OFS_NONE;
    endcase
  end

  // Sequencer: next state, input ready, unit requests, seed step and output load.
  always_comb begin
    state_d    = state_q;
    seed_d     = seed_q;
    md_req     = '{start: 1'b0, op: MD_MUL};
    md_a       = '0;
    md_b       = '0;
    out_load   = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          case (op_e'(s_axis_tuser_i[1:0]))
            OP_MUL_SC: state_d = ST_SM;
            OP_DIV_SC: state_d = ST_SD;
            default:   state_d = (mode_in == OFS_SUB_PRE) ? ST_OFS_DIV : ST_SCALE;
          endcase
        end
      end
      ST_OFS_DIV: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = WIDE_W'(v_abs);
        md_b    = NARROW_W'(NS_PER_S);
        state_d = ST_OFS_DIVW;
      end
      ST_OFS_DIVW: begin
        if (md_rsp.done) begin
          if (micro_q) begin
            state_d = ST_OFS_US;
          end else begin
            state_d = (mode_q == OFS_SUB_PRE) ? ST_PRE_ADD : ST_POST_ADD;
          end
        end
      end
      ST_OFS_US: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = WIDE_W'(fr_q) + WIDE_W'(ofs_k);
        md_b    = NARROW_W'(NS_PER_US);
        state_d = ST_OFS_USW;
      end
      ST_OFS_USW: begin
        if (md_rsp.done) begin
          state_d = (mode_q == OFS_SUB_PRE) ? ST_PRE_ADD : ST_POST_ADD;
        end
      end
      ST_PRE_ADD: state_d = ST_FD;
      ST_FD: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = t_abs;
        md_b    = NARROW_W'(unit);
        state_d = ST_FDW;
      end
      ST_FDW: begin
        if (md_rsp.done) begin
          state_d = ST_FD_FIN;
        end
      end
      ST_FD_FIN: begin
        if (!post_q) begin
          state_d = ST_SCALE;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_SCALE: state_d = (op_q == OP_DIV_TS) ? ST_DI : ST_MI;
      ST_MI: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = WIDE_W'(m_q);
        md_b    = NARROW_W'(fsel);
        state_d = ST_MIW;
      end
      ST_MIW: if (md_rsp.done) state_d = ST_MX;
      ST_MX: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = WIDE_W'(sub_q);
        md_b    = NARROW_W'(fsel);
        state_d = ST_MXW;
      end
      ST_MXW: if (md_rsp.done) state_d = ST_XR;
      ST_DI: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = WIDE_W'(m_q) << FACTOR_FRAC_BITS;
        md_b    = NARROW_W'(fsel);
        state_d = ST_DIW;
      end
      ST_DIW: if (md_rsp.done) state_d = ST_XR;
      ST_XR: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = WIDE_W'(rabs_q);
        md_b    = NARROW_W'(unit);
        state_d = ST_XRW;
      end
      ST_XRW: if (md_rsp.done) state_d = ST_XABS;
      ST_XABS: state_d = ST_RD;
      ST_RD: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = n_rd;
        md_b    = d_rd;
        state_d = ST_RDW;
      end
      ST_RDW: if (md_rsp.done) state_d = ST_IU;
      ST_IU: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = iabs_sgn;
        md_b    = NARROW_W'(unit);
        state_d = ST_IUW;
      end
      ST_IUW: begin
        if (md_rsp.done) begin
          state_d = (mode_q == OFS_ADD_POST) ? ST_OFS_DIV : ST_FD;
        end
      end
      ST_POST_ADD: state_d = ST_OU;
      ST_OU: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = {{(WIDE_W-NARROW_W){osec_q[NARROW_W-1]}}, osec_q};
        md_b    = NARROW_W'(unit);
        state_d = ST_OUW;
      end
      ST_OUW: if (md_rsp.done) state_d = ST_FD;
      ST_SM: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = WIDE_W'(scal_q);
        md_b    = NARROW_W'(fsel);
        state_d = ST_SMW;
      end
      ST_SMW: if (md_rsp.done) state_d = ST_JIT;
      ST_SD: begin
        md_req  = '{start: 1'b1, op: MD_DIV};
        md_a    = WIDE_W'(scal_q) << FACTOR_FRAC_BITS;
        md_b    = NARROW_W'(fsel);
        state_d = ST_SDW;
      end
      ST_SDW: if (md_rsp.done) state_d = ST_JIT;
      ST_JIT: begin
        if (rabs_q == '0) begin
          state_d = ST_SAT;
        end else begin
          seed_d  = 32'(seed_q * JIT_MULT);
          state_d = ST_JM;
        end
      end
      ST_JM: begin
        md_req  = '{start: 1'b1, op: MD_MUL};
        md_a    = WIDE_W'(den_q);
        md_b    = NARROW_W'(seed_q[JIT_BITS-1:0]);
        state_d = ST_JMW;
      end
      ST_JMW: if (md_rsp.done) state_d = ST_SAT;
      ST_SAT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers, configuration and generator seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tf_q    <= FACTOR_ONE;
      off_q   <= '0;
      seed_q  <= 32'd1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_TIME_FACTOR: tf_q  <= cfg_data_i[FACTOR_W-1:0];
          CFG_OFFSET_NS:   off_q <= cfg_data_i;
          default:         tf_q  <= tf_q;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          op_q    <= op_e'(s_axis_tuser_i[1:0]);
          micro_q <= s_axis_tuser_i[2];
          up_q    <= s_axis_tdata_i[0];
          mode_q  <= mode_in;
          s_q     <= {{(NARROW_W-SEC_W){s_axis_tdata_i[43]}}, s_axis_tdata_i[43:3]};
          sub_q   <= s_axis_tdata_i[73:44];
          scal_q  <= s_axis_tdata_i[105:74];
          post_q  <= 1'b0;
          v_q     <= ~off_ext + 64'd1;
        end
      end
      ST_OFS_DIVW: begin
        if (md_rsp.done) begin
          osec_q <= v_q[NARROW_W-1] ? (~md_res[NARROW_W-1:0] + 64'd1)
                                    : md_res[NARROW_W-1:0];
          fr_q   <= md_rem[SUB_W-1:0];
          osub_q <= v_q[NARROW_W-1] ? (~{2'b00, md_rem[SUB_W-1:0]} + 32'd1)
                                    : {2'b00, md_rem[SUB_W-1:0]};
        end
      end
      ST_OFS_USW: begin
        if (md_rsp.done) begin
          osub_q <= v_q[NARROW_W-1] ? (~md_res[31:0] + 32'd1) : md_res[31:0];
        end
      end
      ST_PRE_ADD: begin
        s_q <= s_q + osec_q;
        t_q <= {{(WIDE_W-33){pre_sum[32]}}, pre_sum};
      end
      // Floor division by the unit: remainder always in range.
      ST_FDW: begin
        if (md_rsp.done) begin
          if (!t_q[WIDE_W-1]) begin
            q_q  <= md_res;
            rr_q <= md_rem[SUB_W-1:0];
          end else if (rem_nz) begin
            q_q  <= ~md_res;
            rr_q <= unit - md_rem[SUB_W-1:0];
          end else begin
            q_q  <= ~md_res + 128'd1;
            rr_q <= '0;
          end
        end
      end
      ST_FD_FIN: begin
        if (!post_q) begin
          s_q   <= s_q + q_q[NARROW_W-1:0];
          sub_q <= rr_q;
        end
      end
      ST_SCALE: begin
        neg_q <= s_q[NARROW_W-1];
        m_q   <= s_q[NARROW_W-1] ? (~s_q + 64'd1) : s_q;
      end
      ST_MIW, ST_SMW: begin
        if (md_rsp.done) begin
          iabs_q <= md_res >> FACTOR_FRAC_BITS;
          rabs_q <= FACTOR_W'(md_res[FACTOR_FRAC_BITS-1:0]);
          den_q  <= FACTOR_ONE;
        end
      end
      ST_MXW: if (md_rsp.done) xpos_q <= md_res;
      ST_DIW, ST_SDW: begin
        if (md_rsp.done) begin
          iabs_q <= md_res;
          rabs_q <= md_rem[FACTOR_W-1:0];
          den_q  <= fsel;
          xpos_q <= WIDE_W'(sub_q) << FACTOR_FRAC_BITS;
        end
      end
      ST_XRW: begin
        if (md_rsp.done) begin
          x_q <= neg_q ? (xpos_q - md_res) : (xpos_q + md_res);
        end
      end
      ST_XABS: begin
        xneg_q <= x_q[WIDE_W-1];
        x_q    <= x_q[WIDE_W-1] ? (~x_q + 128'd1) : x_q;
      end
      ST_RDW: begin
        if (md_rsp.done) begin
          rnd_q <= xneg_q ? (~md_res + 128'd1) : md_res;
        end
      end
      ST_IUW: begin
        if (md_rsp.done) begin
          t_q    <= md_res + rnd_q;
          post_q <= 1'b1;
          v_q    <= off_ext;
        end
      end
      ST_POST_ADD: t_q <= t_q + {{(WIDE_W-32){osub_q[31]}}, osub_q};
      ST_OUW: if (md_rsp.done) t_q <= t_q + md_res;
      ST_JMW: begin
        if (md_rsp.done && (md_res > (WIDE_W'(rabs_q) << JIT_BITS))) begin
          iabs_q <= iabs_q + 128'd1;
        end
      end
      default: begin
        t_q <= t_q;
      end
    endcase

    // Result capture with saturation.
    if (out_load) begin
      if (state_q == ST_SAT) begin
        o_sec_q  <= '0;
        o_sub_q  <= '0;
        o_scal_q <= (|iabs_q[WIDE_W-1:SCAL_W]) ? '1 : iabs_q[SCAL_W-1:0];
      end else begin
        o_scal_q <= '0;
        if (pos_ovf) begin
          o_sec_q <= {1'b0, {(SEC_W-1){1'b1}}};
          o_sub_q <= unit - 30'd1;
        end else if (neg_ovf) begin
          o_sec_q <= {1'b1, {(SEC_W-1){1'b0}}};
          o_sub_q <= '0;
        end else begin
          o_sec_q <= q_q[SEC_W-1:0];
          o_sub_q <= rr_q;
        end
      end
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {1'b0, o_scal_q, o_sub_q, o_sec_q};

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!ov_q || m_axis_tready_i))
    else $error("result register overwritten");

  // The arithmetic unit is only started when it is free.
  a_md_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_rsp.busy)
    else $error("arithmetic unit started while busy");

  // An accepted request always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> (state_q != ST_IDLE))
    else $error("accepted request dropped");

  // The seed stays odd, so the generator never locks at zero.
  a_seed_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q[0])
    else $error("jitter seed became even");

endmodule

FILE: rtl/tvs_muldiv.sv
// Shared bit-serial arithmetic unit. A multiply is shift-and-add, one
// multiplier bit per cycle, ending when no set bit is left. A divide is
// restoring division, one quotient bit per cycle over the whole dividend.
module tvs_muldiv
  import tvs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  md_req_t             req_i,
  input  logic [WIDE_W-1:0]   a_i,
  input  logic [NARROW_W-1:0] b_i,
  output md_rsp_t             rsp_o,
  output logic [WIDE_W-1:0]   res_o,
  output logic [NARROW_W-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  md_op_e             op_q, op_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WIDE_W-1:0]  acc_q, acc_d;
  logic [WIDE_W-1:0]  sh_q, sh_d;
  logic [NARROW_W-1:0] b_q, b_d;
  logic [NARROW_W-1:0] rem_q, rem_d;

  // Partial remainder with the next dividend bit brought in.
  logic [NARROW_W:0] rs;
  logic [NARROW_W:0] rdiff;
  logic              ge;

  assign rs    = {rem_q, sh_q[WIDE_W-1]};
  assign rdiff = rs - {1'b0, b_q};
  assign ge    = rs >= {1'b0, b_q};

  // Step logic.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '1;
      acc_d  = '0;
      sh_d   = a_i;
      b_d    = b_i;
      rem_d  = '0;
    end else if (busy_q) begin
      unique case (op_q)
        MD_MUL: begin
          if (b_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            if (b_q[0]) begin
              acc_d = acc_q + sh_q;
            end
            sh_d = sh_q << 1;
            b_d  = b_q >> 1;
          end
        end
        MD_DIV: begin
          rem_d = ge ? rdiff[NARROW_W-1:0] : rs[NARROW_W-1:0];
          sh_d  = {sh_q[WIDE_W-2:0], ge};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = (op_q == MD_MUL) ? acc_q : sh_q;
  assign rem_o      = rem_q;

endmodule
